// ===== rtl/core/gha_pkg.sv =====
// Shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

    localparam int HANDLE_BITS = 32;
    localparam int STATUS_BITS = 2;

    localparam logic CMD_CREATE  = 1'b0;
    localparam logic CMD_DESTROY = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_STALE = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } gha_state_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic commit;
    } gha_ctrl_t;

    typedef struct packed {
        logic out_free;
        logic out_valid;
    } gha_stat_t;

endpackage

// ===== rtl/core/gha_ctrl.sv =====
// Sequencer for the allocator: accept, fetch, execute.
`timescale 1ns / 1ps

module gha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gha_pkg::gha_stat_t  stat,
    output gha_pkg::gha_ctrl_t  ctrl
);
    import gha_pkg::*;

    gha_state_t state_reg;
    gha_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.fetch   = 1'b0;
        ctrl.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                ctrl.capture = s_tvalid;
            end
            S_FETCH:
            begin
                ctrl.fetch = 1'b1;
            end
            S_EXEC:
            begin
                ctrl.commit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> ctrl.fetch)
        else $error("accepted item not fetched");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fetch |=> state_reg == S_EXEC && !s_tready)
        else $error("fetch not followed by execute");

endmodule

// ===== rtl/core/gha_datapath.sv =====
// Version memory, free stack, counters and result register of the allocator.
`timescale 1ns / 1ps

module gha_datapath #(
    parameter int INDEX_BITS   = 10,
    parameter int VERSION_BITS = 22
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gha_pkg::gha_ctrl_t                ctrl,
    output gha_pkg::gha_stat_t                stat,
    input  logic                              cmd_in,
    input  logic [gha_pkg::HANDLE_BITS-1:0]   handle_in,
    output logic [gha_pkg::HANDLE_BITS-1:0]   handle_out,
    output logic [gha_pkg::STATUS_BITS-1:0]   status_out,
    input  logic                              out_ready
);
    import gha_pkg::*;

    localparam int SLOT_COUNT = 1 << INDEX_BITS;
    localparam int CNT_BITS   = INDEX_BITS + 1;
    localparam int PAIR_BITS  = INDEX_BITS + VERSION_BITS;

    logic [VERSION_BITS-1:0] version_mem [SLOT_COUNT];
    logic [INDEX_BITS-1:0]   stack_mem   [SLOT_COUNT];

    logic                    cmd_reg;
    logic [HANDLE_BITS-1:0]  hin_reg;
    logic [INDEX_BITS-1:0]   stack_rd_reg;
    logic [VERSION_BITS-1:0] ver_rd_reg;
    logic [CNT_BITS-1:0]     free_count_reg;
    logic [CNT_BITS-1:0]     free_count_next;
    logic [CNT_BITS-1:0]     slots_used_reg;
    logic [CNT_BITS-1:0]     slots_used_next;
    logic                    out_valid_reg;
    logic [HANDLE_BITS-1:0]  out_handle_reg;
    logic [HANDLE_BITS-1:0]  out_handle_next;
    logic [STATUS_BITS-1:0]  out_status_reg;
    logic [STATUS_BITS-1:0]  out_status_next;

    logic [INDEX_BITS-1:0]   stack_raddr;
    logic [INDEX_BITS-1:0]   ver_raddr;
    logic [INDEX_BITS-1:0]   hin_idx;
    logic [INDEX_BITS-1:0]   fresh_idx;
    logic                    ver_we;
    logic [INDEX_BITS-1:0]   ver_waddr;
    logic [VERSION_BITS-1:0] ver_wdata;
    logic                    stack_we;
    logic [INDEX_BITS-1:0]   stack_waddr;
    logic                    free_empty;
    logic                    table_full;
    logic                    stack_full;

    function automatic logic [HANDLE_BITS-1:0] make_handle(
        input logic [VERSION_BITS-1:0] ver,
        input logic [INDEX_BITS-1:0]   idx
    );
        logic [PAIR_BITS+HANDLE_BITS-1:0] ext;
        ext = {{HANDLE_BITS{1'b0}}, ver, idx};
        return ext[HANDLE_BITS-1:0];
    endfunction

    assign hin_idx     = hin_reg[INDEX_BITS-1:0];
    assign fresh_idx   = slots_used_reg[INDEX_BITS-1:0];
    assign free_empty  = (free_count_reg == '0);
    assign table_full  = slots_used_reg[INDEX_BITS];
    assign stack_full  = free_count_reg[INDEX_BITS];
    assign stack_raddr = free_count_reg[INDEX_BITS-1:0] - {{(INDEX_BITS-1){1'b0}}, 1'b1};
    assign ver_raddr   = (cmd_reg == CMD_CREATE) ? stack_rd_reg : hin_idx;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg      <= cmd_in;
            hin_reg      <= handle_in;
            stack_rd_reg <= stack_mem[stack_raddr];
        end
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= hin_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fetch)
        begin
            ver_rd_reg <= version_mem[ver_raddr];
        end
        if (ver_we)
        begin
            version_mem[ver_waddr] <= ver_wdata;
        end
    end

    always_comb
    begin
        free_count_next = free_count_reg;
        slots_used_next = slots_used_reg;
        out_handle_next = '0;
        out_status_next = ST_OK;
        ver_we          = 1'b0;
        ver_waddr       = hin_idx;
        ver_wdata       = ver_rd_reg + {{(VERSION_BITS-1){1'b0}}, 1'b1};
        stack_we        = 1'b0;
        stack_waddr     = free_count_reg[INDEX_BITS-1:0];
        if (cmd_reg == CMD_CREATE)
        begin
            if (!free_empty)
            begin
                free_count_next = free_count_reg - {{(CNT_BITS-1){1'b0}}, 1'b1};
                out_handle_next = make_handle(ver_rd_reg, stack_rd_reg);
            end
            else if (!table_full)
            begin
                ver_we          = ctrl.commit;
                ver_waddr       = fresh_idx;
                ver_wdata       = {{(VERSION_BITS-1){1'b0}}, 1'b1};
                slots_used_next = slots_used_reg + {{(CNT_BITS-1){1'b0}}, 1'b1};
                out_handle_next = make_handle({{(VERSION_BITS-1){1'b0}}, 1'b1}, fresh_idx);
            end
            else
            begin
                out_status_next = ST_FULL;
            end
        end
        else
        begin
            if ({1'b0, hin_idx} >= slots_used_reg)
            begin
                out_status_next = ST_RANGE;
            end
            else if (make_handle(ver_rd_reg, hin_idx) != hin_reg)
            begin
                out_status_next = ST_STALE;
            end
            else
            begin
                ver_we = ctrl.commit;
                if (!stack_full)
                begin
                    stack_we        = ctrl.commit;
                    free_count_next = free_count_reg + {{(CNT_BITS-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            slots_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.commit)
            begin
                free_count_reg <= free_count_next;
                slots_used_reg <= slots_used_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_handle_reg <= out_handle_next;
            out_status_reg <= out_status_next;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.out_valid = out_valid_reg;
    assign handle_out     = out_handle_reg;
    assign status_out     = out_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.commit))
        else $error("result appeared without commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_handle_reg == '0)
        else $error("failed request returned a nonzero handle");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && cmd_reg == CMD_CREATE && free_empty && !table_full
        |=> slots_used_reg == $past(slots_used_reg) + 1'b1 && out_status_reg == ST_OK)
        else $error("fresh create did not advance high-water count");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && out_status_next != ST_OK
        |=> $stable(free_count_reg) && $stable(slots_used_reg))
        else $error("rejected request changed counters");

endmodule

// ===== rtl/core/generational_handle_allocator_core.sv =====
// Generational handle allocator: top level joining sequencer and datapath.
//
// Usage: each request item on the s_ channel carries a command in s_tuser
// (0 create, 1 destroy) and a handle in s_tdata (used by destroy only).
// Each request yields exactly one result item on the m_ channel: the new
// handle in m_tdata (zero on destroy or failure) and a status in m_tuser
// (0 ok, 1 table full, 2 index out of range, 3 stale version).
// A handle holds the slot version above the low INDEX_BITS index bits.
// An accepted item goes through fetch and execute before its result is
// registered; no new item is taken until it commits, set by the dependent
// stack read and version read of the memories before the read-modify-write
// commits. A new item is accepted while the previous result waits on
// m_tready; if the receiver stalls, the next item holds in its execute
// step until the result register frees up. Reset clears the free-stack
// count, the high-water count and the result valid flag; the memories need
// no clearing pass, so items are accepted as soon as reset is released.
`timescale 1ns / 1ps

module generational_handle_allocator_core #(
    parameter int INDEX_BITS   = 10,
    parameter int VERSION_BITS = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // handle_in[31:0]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // handle_out[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import gha_pkg::*;

    gha_ctrl_t ctrl;
    gha_stat_t stat;

    gha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    gha_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .VERSION_BITS (VERSION_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cmd_in     (s_tuser[0]),
        .handle_in  (s_tdata),
        .handle_out (m_tdata),
        .status_out (m_tuser),
        .out_ready  (m_tready)
    );

    assign m_tvalid = stat.out_valid;

endmodule
